@@ rtl/mit_pkg.sv @@
package mit_pkg;

  localparam int TS_W    = 64;
  localparam int COUNT_W = 7;

  // item kinds
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_ADD    = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_MISS   = 2'd0,
    ST_HIT    = 2'd1,
    ST_ADDED  = 2'd2,
    ST_REJECT = 2'd3
  } status_t;

  // one stored range, start in the upper half
  typedef struct packed {
    logic signed [TS_W-1:0] beg_ts;
    logic signed [TS_W-1:0] end_ts;
  } range_t;

endpackage

@@ rtl/mit_in_if.sv @@
interface mit_in_if;
  import mit_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic signed [TS_W-1:0] target_ts;
  logic signed [TS_W-1:0] range_start;
  logic signed [TS_W-1:0] range_end;

  modport source (output valid, kind, target_ts, range_start, range_end, input ready);
  modport sink (input valid, kind, target_ts, range_start, range_end, output ready);
endinterface

@@ rtl/mit_out_if.sv @@
interface mit_out_if;
  import mit_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic signed [TS_W-1:0] hit_start;
  logic signed [TS_W-1:0] hit_end;
  logic [COUNT_W-1:0]     entry_count;

  modport source (output valid, status, hit_start, hit_end, entry_count, input ready);
  modport sink (input valid, status, hit_start, hit_end, entry_count, output ready);
endinterface

@@ rtl/mit_ram.sv @@
module mit_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/merging_interval_table.sv @@
// merging_interval_table: sorted table of disjoint closed timestamp ranges.
// in_ch carries one item per valid/ready handshake: a lookup (kind 0) of
// target_ts or an add (kind 1) of [range_start, range_end]. out_ch returns
// exactly one result per item: status, the hit range and the entry count.
// cfg_we/cfg_wdata write max_entries, the occupancy at which an add first
// thins the table; write it only while the block is idle.
// All ranges sit in one memory (start and end side by side) with a
// registered read port; a sequencer walks it one entry at a time.
// A lookup scans the n stored ranges in order until a hit or the end. An
// add finds the ranges it overlaps, shifts the entries behind them and
// writes the merged range; when n has reached max_entries or CAPACITY, a
// thinning pass first roughly halves n; the single port sets the pace.
// One item is worked on at a time; in_ch.ready is high only when idle.
// The result waits in an output register; a stalled receiver holds the
// finished result and the sequencer waits before loading the next one, so
// a new item may be accepted while a result is still pending.
// Reset empties the table and sets max_entries to 64; no clearing pass.
module merging_interval_table #(
  parameter int CAPACITY = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  mit_in_if.sink                 in_ch,
  mit_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [mit_pkg::COUNT_W-1:0] cfg_wdata
);
  import mit_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int RW = 2 * TS_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LK_RD, S_LK_CK, S_TH_RD, S_TH_WR, S_HI_RD, S_HI_CK, S_LO_RD,
    S_LO_CK, S_DEC, S_SH_UP, S_SH_UPW, S_SH_DN, S_SH_DNW, S_INS, S_FIN
  } state_t;

  state_t                 state_r;
  logic [COUNT_W-1:0]     max_r;
  logic [CW-1:0]          n_r, i_r, w_r, lo_r, hi_r, rm_r;
  logic signed [TS_W-1:0] ms_r, me_r, tgt_r;
  logic [1:0]             res_st_r;
  logic signed [TS_W-1:0] res_hs_r, res_he_r;
  logic                   out_valid_r;
  logic [1:0]             out_st_r;
  logic signed [TS_W-1:0] out_hs_r, out_he_r;
  logic [COUNT_W-1:0]     out_cnt_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [RW-1:0] mem_wdata, mem_rdata;
  range_t        rd;
  logic [MW-1:0] n_ext;
  logic [CW:0]   new_n;
  logic          keep;
  logic          out_free;

  assign rd       = range_t'(mem_rdata);
  assign n_ext    = MW'(n_r);
  assign new_n    = {1'b0, n_r} - {1'b0, hi_r - lo_r} + (CW+1)'(1);
  assign keep     = (i_r == '0) || (i_r == n_r - CW'(1)) || !i_r[0];
  assign out_free = !out_valid_r || out_ch.ready;

  mit_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = i_r[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = i_r[AW-1:0];
    case (state_r)
      S_LO_RD: begin
        mem_raddr = AW'(lo_r - CW'(1));
      end
      S_SH_UP: begin
        mem_raddr = AW'(i_r - CW'(1));
      end
      S_TH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = w_r[AW-1:0];
      end
      S_SH_UPW: begin
        mem_we = 1'b1;
      end
      S_SH_DNW: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(i_r - rm_r + CW'(1));
      end
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r[AW-1:0];
        mem_wdata = {ms_r, me_r};
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_r       <= COUNT_W'(64);
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      // result taken and no new one loaded this cycle
      if (out_valid_r && out_ch.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            i_r      <= '0;
            w_r      <= '0;
            tgt_r    <= in_ch.target_ts;
            ms_r     <= in_ch.range_start;
            me_r     <= in_ch.range_end;
            res_hs_r <= '0;
            res_he_r <= '0;
            if (in_ch.kind == KIND_LOOKUP) begin
              res_st_r <= ST_MISS;
              state_r  <= S_LK_RD;
            end else if (in_ch.range_start > in_ch.range_end) begin
              res_st_r <= ST_REJECT;
              state_r  <= S_FIN;
            end else if (n_ext >= MW'(max_r) || n_r >= CW'(CAPACITY)) begin
              state_r <= S_TH_RD;
            end else begin
              state_r <= S_HI_RD;
            end
          end
        end
        // lookup scan
        S_LK_RD: begin
          state_r <= (i_r == n_r) ? S_FIN : S_LK_CK;
        end
        S_LK_CK: begin
          if (tgt_r >= rd.beg_ts && tgt_r <= rd.end_ts) begin
            res_st_r <= ST_HIT;
            res_hs_r <= rd.beg_ts;
            res_he_r <= rd.end_ts;
            state_r  <= S_FIN;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_LK_RD;
          end
        end
        // thinning, compacted in place
        S_TH_RD: begin
          if (i_r == n_r) begin
            n_r     <= w_r;
            i_r     <= '0;
            state_r <= S_HI_RD;
          end else if (keep) begin
            state_r <= S_TH_WR;
          end else begin
            i_r <= i_r + CW'(1);
          end
        end
        S_TH_WR: begin
          w_r     <= w_r + CW'(1);
          i_r     <= i_r + CW'(1);
          state_r <= S_TH_RD;
        end
        // first entry starting past the new end
        S_HI_RD: begin
          if (i_r == n_r) begin
            hi_r    <= i_r;
            lo_r    <= i_r;
            state_r <= S_LO_RD;
          end else begin
            state_r <= S_HI_CK;
          end
        end
        S_HI_CK: begin
          if (rd.beg_ts <= me_r) begin
            i_r     <= i_r + CW'(1);
            state_r <= S_HI_RD;
          end else begin
            hi_r    <= i_r;
            lo_r    <= i_r;
            state_r <= S_LO_RD;
          end
        end
        // walk back over ranges reaching the new start, widen the merge
        S_LO_RD: begin
          state_r <= (lo_r == '0) ? S_DEC : S_LO_CK;
        end
        S_LO_CK: begin
          if (rd.end_ts >= ms_r) begin
            if (rd.beg_ts < ms_r) ms_r <= rd.beg_ts;
            if (rd.end_ts > me_r) me_r <= rd.end_ts;
            lo_r    <= lo_r - CW'(1);
            state_r <= S_LO_RD;
          end else begin
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          rm_r <= hi_r - lo_r;
          if (new_n > (CW+1)'(CAPACITY)) begin
            res_st_r <= ST_REJECT;
            state_r  <= S_FIN;
          end else if (hi_r == lo_r) begin
            i_r     <= n_r;
            state_r <= S_SH_UP;
          end else begin
            i_r     <= hi_r;
            state_r <= S_SH_DN;
          end
        end
        // open a slot at lo
        S_SH_UP: begin
          state_r <= (i_r == lo_r) ? S_INS : S_SH_UPW;
        end
        S_SH_UPW: begin
          i_r     <= i_r - CW'(1);
          state_r <= S_SH_UP;
        end
        // close the gap left by merged ranges
        S_SH_DN: begin
          state_r <= (i_r == n_r) ? S_INS : S_SH_DNW;
        end
        S_SH_DNW: begin
          i_r     <= i_r + CW'(1);
          state_r <= S_SH_DN;
        end
        S_INS: begin
          n_r      <= new_n[CW-1:0];
          res_st_r <= ST_ADDED;
          state_r  <= S_FIN;
        end
        // hand the item's result to the output register
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_st_r    <= res_st_r;
            out_hs_r    <= res_hs_r;
            out_he_r    <= res_he_r;
            out_cnt_r   <= n_ext[COUNT_W-1:0];
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.hit_start   = out_hs_r;
  assign out_ch.hit_end     = out_he_r;
  assign out_ch.entry_count = out_cnt_r;
endmodule
